@@ hw/rtl/tlbpt_pkg.sv @@
// tlbpt_pkg: shared constants of the page translator
// default geometry and the packed widths of the stream payloads
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlbpt_pkg;

    localparam int unsigned DEF_TLB_ENTRIES = 16;
    localparam int unsigned DEF_OFFSET_BITS = 8;
    localparam int unsigned DEF_PAGE_BITS   = 8;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned COUNT_W = 32;

    // result fields packed from bit 0: phys, hit, fault, hit total, fault total
    localparam int unsigned RES_BITS = ADDR_W + 2 + 2 * COUNT_W;
    localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ hw/rtl/tlbpt_ram.sv @@
// tlbpt_ram: generic single-write, single-read synchronous ram
// read data registered; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tlb_lru_page_translator.sv @@
// tlb_lru_page_translator: logical to physical page translation with an lru tlb
// depends on tlbpt_pkg and tlbpt_ram (page table storage)
//
// usage
//   s_* carries one logical address per transaction (page above OFFSET_BITS,
//   offset below). m_* returns exactly one result per input transaction:
//   physical address, tlb hit flag, page fault flag and the saturating hit and
//   fault totals after this access.
//   the tlb (tag, frame, valid, recency rank per entry) sits in flops so all
//   entries compare at once; the page table (valid + frame per page) lives in a
//   synchronous ram with registered read data.
//   flow: an address accepted in ST_IDLE starts its page table read; ST_LOOK
//   then compares, picks the lru victim, writes back the tlb, ranks and page
//   table entry and loads the output register once that register is free.
//   m_tvalid rises as the output register is loaded, and no new address is
//   taken until the current one is written back.
//   the page table write happens before the next read can issue, so no
//   forwarding is needed.
//   reset: all tlb entries invalid, counters and free frame pointer cleared,
//   then a clearing pass over all 2**PAGE_BITS page table entries (256 by
//   default) zeroes the page table; s_tready stays low until it ends.
//   stall: while the output register holds an untaken result, the next address
//   can still be accepted and read; its write-back waits until m_tready frees
//   the output register.
`timescale 1ns / 1ps
`default_nettype none

module tlb_lru_page_translator
    import tlbpt_pkg::*;
#(
    parameter int unsigned TLB_ENTRIES = DEF_TLB_ENTRIES,
    parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS,
    parameter int unsigned PAGE_BITS   = DEF_PAGE_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ADDR_W-1:0] s_tdata,   // [15:0] virt_addr
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [15:0] phys_addr, [16] tlb_hit, [17] page_fault,
    // [49:18] hit_total, [81:50] fault_total, [87:82] zero
    output logic [RES_W-1:0]       m_tdata
);

    localparam int unsigned IDX_W    = $clog2(TLB_ENTRIES);
    localparam int unsigned RANK_W   = $clog2(TLB_ENTRIES);
    localparam int unsigned NPAGES   = 1 << PAGE_BITS;
    localparam int unsigned MAP_W    = PAGE_BITS + 1;
    localparam logic [RANK_W-1:0] OLDEST = RANK_W'(TLB_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t state_reg, state_next;

    // tlb entries
    logic [PAGE_BITS-1:0] tlb_tag_reg   [TLB_ENTRIES];
    logic [PAGE_BITS-1:0] tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg, tlb_valid_next;
    logic [RANK_W-1:0]    rank_reg  [TLB_ENTRIES];
    logic [RANK_W-1:0]    rank_next [TLB_ENTRIES];

    // scalar state
    logic [PAGE_BITS:0]   free_frame_reg, free_frame_next;
    logic [COUNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]   fault_cnt_reg, fault_cnt_next;
    logic [PAGE_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [RES_W-1:0]     m_tdata_reg, m_tdata_next;

    // page table ram
    logic                 map_we;
    logic [PAGE_BITS-1:0] map_waddr;
    logic [MAP_W-1:0]     map_wdata;
    logic                 map_re;
    logic [PAGE_BITS-1:0] map_raddr;
    logic [MAP_W-1:0]     map_rdata;

    tlbpt_ram #(
        .WIDTH (MAP_W),
        .DEPTH (NPAGES)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // address split; page bits above bit 15 read as zero
    logic [31:0]          in_wide;
    logic [31:0]          cur_wide;
    logic [PAGE_BITS-1:0] in_page;
    logic [PAGE_BITS-1:0] cur_page;
    logic [31:0]          offset_wide;

    assign in_wide     = 32'(s_tdata);
    assign cur_wide    = 32'(addr_reg);
    assign in_page     = in_wide[OFFSET_BITS +: PAGE_BITS];
    assign cur_page    = cur_wide[OFFSET_BITS +: PAGE_BITS];
    assign offset_wide = cur_wide & ((32'd1 << OFFSET_BITS) - 32'd1);

    logic accept;
    logic out_free;
    logic fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = (state_reg == ST_LOOK) && out_free;

    // parallel tag compare
    logic [TLB_ENTRIES-1:0] hit_vec;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [PAGE_BITS-1:0]   hit_frame;

    always_comb
    begin
        hit_idx   = '0;
        hit_frame = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            hit_vec[i] = tlb_valid_reg[i] && (tlb_tag_reg[i] == cur_page);
        end
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx   = IDX_W'(i);
                hit_frame = tlb_frame_reg[i];
            end
        end
        hit = |hit_vec;
    end

    // victim: lowest empty entry, else the one holding the oldest rank
    logic [IDX_W-1:0] slot_idx;
    logic             any_empty;

    always_comb
    begin
        slot_idx  = '0;
        any_empty = !(&tlb_valid_reg);
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (any_empty)
            begin
                if (!tlb_valid_reg[i])
                begin
                    slot_idx = IDX_W'(i);
                end
            end
            else if (rank_reg[i] == OLDEST)
            begin
                slot_idx = IDX_W'(i);
            end
        end
    end

    // translation result
    logic                 map_present;
    logic                 fault;
    logic [PAGE_BITS-1:0] frame;
    logic [IDX_W-1:0]     touch_idx;
    logic [RANK_W:0]      touch_old;
    logic [31:0]          phys_wide;

    always_comb
    begin
        map_present = map_rdata[PAGE_BITS];
        fault       = !hit && !map_present;
        if (hit)
        begin
            frame = hit_frame;
        end
        else if (fault)
        begin
            frame = free_frame_reg[PAGE_BITS-1:0];
        end
        else
        begin
            frame = map_rdata[PAGE_BITS-1:0];
        end
        touch_idx = hit ? hit_idx : slot_idx;
        touch_old = tlb_valid_reg[touch_idx] ? {1'b0, rank_reg[touch_idx]}
                                             : (RANK_W + 1)'(TLB_ENTRIES);
        phys_wide = (32'(frame) << OFFSET_BITS) | offset_wide;
    end

    // rank aging: entries younger than the touched one move back by one
    always_comb
    begin
        tlb_valid_next = tlb_valid_reg;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (fire)
            begin
                if (IDX_W'(i) == touch_idx)
                begin
                    rank_next[i] = '0;
                end
                else if (tlb_valid_reg[i] && ({1'b0, rank_reg[i]} < touch_old))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
        end
        if (fire && !hit)
        begin
            tlb_valid_next[slot_idx] = 1'b1;
        end
    end

    // page table port control
    always_comb
    begin
        map_re    = accept;
        map_raddr = in_page;
        map_we    = 1'b0;
        map_waddr = cur_page;
        map_wdata = {1'b1, frame};
        if (state_reg == ST_CLEAR)
        begin
            map_we    = 1'b1;
            map_waddr = clr_cnt_reg;
            map_wdata = '0;
        end
        else if (fire && fault)
        begin
            map_we = 1'b1;
        end
    end

    // sequencer and output register
    always_comb
    begin
        state_next      = state_reg;
        free_frame_next = free_frame_reg;
        hit_cnt_next    = hit_cnt_reg;
        fault_cnt_next  = fault_cnt_reg;
        clr_cnt_next    = clr_cnt_reg;
        addr_next       = addr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = s_tdata;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (fire)
                begin
                    if (hit && !(&hit_cnt_reg))
                    begin
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                    end
                    if (fault)
                    begin
                        free_frame_next = free_frame_reg + 1'b1;
                        if (!(&fault_cnt_reg))
                        begin
                            fault_cnt_next = fault_cnt_reg + 1'b1;
                        end
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = RES_W'({fault_cnt_next, hit_cnt_next, fault, hit,
                                            phys_wide[ADDR_W-1:0]});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            free_frame_reg <= '0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            clr_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_frame_reg <= free_frame_next;
            hit_cnt_reg    <= hit_cnt_next;
            fault_cnt_reg  <= fault_cnt_next;
            clr_cnt_reg    <= clr_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        m_tdata_reg <= m_tdata_next;
        if (fire && !hit)
        begin
            tlb_tag_reg[slot_idx]   <= cur_page;
            tlb_frame_reg[slot_idx] <= frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg <= '0;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            tlb_valid_reg <= tlb_valid_next;
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a page never sits in two tlb entries
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> $onehot0(hit_vec))
        else $error("page matched more than one tlb entry");

    // a result is never both a tlb hit and a page fault
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid && !(m_tdata[ADDR_W] && m_tdata[ADDR_W+1]))
        else $error("result flagged as hit and fault");

    // no new address is taken until the current one is written back
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second address accepted during lookup");

    // totals never go backward
    a_totals_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (hit_cnt_reg >= $past(hit_cnt_reg))
              && (fault_cnt_reg >= $past(fault_cnt_reg)))
        else $error("hit or fault total decreased");

endmodule

`default_nettype wire

@@ test/tlb_lru_page_translator_test.sv @@
// tlb_lru_page_translator_test: self-checking stream testbench of the lru page translator
// drives logical addresses, predicts every translation and compares the results
// depends on tlbpt_pkg and tlb_lru_page_translator
`timescale 1ns / 1ps

module tlb_lru_page_translator_test;
    import tlbpt_pkg::*;

    localparam int unsigned TLB_N  = DEF_TLB_ENTRIES;
    localparam int unsigned OFF_W  = DEF_OFFSET_BITS;
    localparam int unsigned PAGE_W = DEF_PAGE_BITS;
    localparam int unsigned NPAGES = 1 << PAGE_W;

    localparam int unsigned HOT_SET      = 20;     // a little more than the tlb holds
    localparam int unsigned RANDOM_ITEMS = 1120;
    localparam int unsigned QUIET_ITEMS  = 150;    // tail of the run with no idling
    localparam int unsigned LONG_HOLD    = 80;     // receiver hold-off, in cycles
    localparam int unsigned DRAIN_CYCLES = 10;

    // one predicted translation, in the order of the result fields
    typedef struct {
        logic [ADDR_W-1:0]  phys;
        logic               hit;
        logic               fault;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] fault_total;
    } translation_t;

    // mirror of the tlb, page table and counters; holds the translations still owed
    class page_translation_board;
        logic [PAGE_W-1:0]  entry_tag   [TLB_N];
        logic [PAGE_W-1:0]  entry_frame [TLB_N];
        bit                 entry_valid [TLB_N];
        int unsigned        entry_rank  [TLB_N];
        bit                 page_mapped [NPAGES];
        logic [PAGE_W-1:0]  page_frame  [NPAGES];
        logic [PAGE_W:0]    free_frame;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] faults;
        translation_t       expected_translations [$];
        int unsigned        errors;

        function new();
            foreach (entry_valid[i])
            begin
                entry_valid[i] = 1'b0;
                entry_rank[i]  = 0;
            end
            foreach (page_mapped[i])
                page_mapped[i] = 1'b0;
            free_frame = '0;
            hits       = '0;
            faults     = '0;
            errors     = 0;
        endfunction

        // entry becomes rank 0, valid entries younger than it age by one
        function void promote(int unsigned e);
            int unsigned old_rank;
            old_rank = entry_valid[e] ? entry_rank[e] : TLB_N;
            for (int unsigned i = 0; i < TLB_N; i++)
                if (i != e && entry_valid[i] && entry_rank[i] < old_rank)
                    entry_rank[i]++;
            entry_rank[e] = 0;
        endfunction

        // lowest empty entry, else the oldest one
        function int unsigned victim();
            int unsigned best;
            for (int unsigned i = 0; i < TLB_N; i++)
                if (!entry_valid[i])
                    return i;
            best = 0;
            for (int unsigned i = 1; i < TLB_N; i++)
                if (entry_rank[i] > entry_rank[best])
                    best = i;
            return best;
        endfunction

        function void note_address(input logic [ADDR_W-1:0] addr);
            translation_t      t;
            logic [PAGE_W-1:0] page;
            logic [OFF_W-1:0]  offset;
            logic [PAGE_W-1:0] frame;
            int unsigned       slot;
            page    = addr[OFF_W +: PAGE_W];
            offset  = addr[OFF_W-1:0];
            frame   = '0;
            t.hit   = 1'b0;
            t.fault = 1'b0;
            for (int unsigned i = 0; i < TLB_N; i++)
            begin
                if (!t.hit && entry_valid[i] && entry_tag[i] == page)
                begin
                    t.hit = 1'b1;
                    frame = entry_frame[i];
                    promote(i);
                end
            end
            if (t.hit)
            begin
                if (hits != '1)
                    hits++;
            end
            else
            begin
                // page fault: hand out the next frame, wrapping when frames run out
                if (!page_mapped[page])
                begin
                    t.fault           = 1'b1;
                    page_mapped[page] = 1'b1;
                    page_frame[page]  = free_frame[PAGE_W-1:0];
                    free_frame++;
                    if (faults != '1)
                        faults++;
                end
                frame = page_frame[page];
                slot  = victim();
                promote(slot);
                entry_tag[slot]   = page;
                entry_frame[slot] = frame;
                entry_valid[slot] = 1'b1;
            end
            t.phys        = ADDR_W'({frame, offset});
            t.hit_total   = hits;
            t.fault_total = faults;
            expected_translations.push_back(t);
        endfunction

        function void compare_field(input string name, input logic [COUNT_W-1:0] want,
                                    input logic [COUNT_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input logic [RES_W-1:0] word);
            translation_t want;
            if (expected_translations.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, expected none, actual %h",
                         $time, word);
                errors++;
                return;
            end
            want = expected_translations.pop_front();
            compare_field("phys_addr", COUNT_W'(want.phys), COUNT_W'(word[ADDR_W-1:0]));
            compare_field("tlb_hit", COUNT_W'(want.hit), COUNT_W'(word[ADDR_W]));
            compare_field("page_fault", COUNT_W'(want.fault), COUNT_W'(word[ADDR_W+1]));
            compare_field("hit_total", want.hit_total, word[ADDR_W+2 +: COUNT_W]);
            compare_field("fault_total", want.fault_total, word[ADDR_W+2+COUNT_W +: COUNT_W]);
        endfunction

        function int unsigned pending();
            return expected_translations.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [ADDR_W-1:0] s_tdata;    // [15:0] virt_addr
    logic              m_tvalid;
    logic              m_tready;
    // [15:0] phys_addr, [16] tlb_hit, [17] page_fault,
    // [49:18] hit_total, [81:50] fault_total, [87:82] zero
    logic [RES_W-1:0]  m_tdata;

    page_translation_board board = new();

    // idling controls, shared between the stimulus and the result sink
    bit tx_gaps_on    = 1'b1;
    bit rx_stalls_on  = 1'b1;
    bit long_hold_req = 1'b0;

    tlb_lru_page_translator #(
        .TLB_ENTRIES (TLB_N),
        .OFFSET_BITS (OFF_W),
        .PAGE_BITS   (PAGE_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous bound: clearing pass plus every item at its slowest, several times over
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // sender goes quiet for a number of cycles; data is a don't-care meanwhile
    task automatic idle_sender(input int unsigned cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= ADDR_W'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    // offers one address from a falling edge, returns at the falling edge after the transaction
    // valid stays high into the next send unless a gap is inserted
    task automatic send_address(input logic [ADDR_W-1:0] addr);
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_address(addr);
        @(negedge clk);
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
            idle_sender($urandom_range(1, 12));
    endtask

    // sender stops until every owed translation has come back
    task automatic wait_for_results();
        if (board.pending() != 0)
        begin
            s_tvalid <= 1'b0;
            while (board.pending() != 0)
                @(negedge clk);
        end
    endtask

    // result sink: random stall bursts, or one long hold-off on request
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            else if (rx_stalls_on && hold_left == 0 && $urandom_range(0, 7) == 0)
                hold_left = $urandom_range(1, 12);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // every result transaction is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    initial
    begin : stimulus
        logic [PAGE_W-1:0] hot_pages [HOT_SET];
        logic [PAGE_W-1:0] sweep_page;
        logic [PAGE_W-1:0] pg;
        int unsigned       n;
        int unsigned       k;
        int unsigned       mode;
        int unsigned       run_len;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: pages 0 and 255 each fault first, then hit, at both offset extremes
        send_address(16'h0000);
        send_address(16'h00ff);
        send_address(16'hffff);
        send_address(16'hff00);
        // fill the remaining tlb entries with fresh pages
        for (k = 1; k <= 14; k++)
            send_address({PAGE_W'(k), (k[0] ? 8'h55 : 8'haa)});
        // full tlb: these evict the two least recently used entries (pages 0 and 255)
        send_address(16'h0f3c);
        send_address(16'h10c3);
        // page 0 is mapped but no longer cached: tlb miss without a fault
        send_address(16'h0012);
        // page 255 likewise, then a hit on an entry that has aged
        send_address(16'hff80);
        send_address(16'h0501);
        // mid-range pages with complementary address bits
        send_address(16'h8000);
        send_address(16'h7fff);

        // pause until the pipeline is empty
        wait_for_results();

        // long receiver hold-off while addresses keep coming back to back
        tx_gaps_on    = 1'b0;
        long_hold_req = 1'b1;
        for (k = 0; k < 12; k++)
            send_address({PAGE_W'($urandom_range(0, 20)), OFF_W'($urandom)});
        tx_gaps_on = 1'b1;
        wait_for_results();

        // random part: mostly a locality working set larger than the tlb, sweeps that
        // fault every page in turn until frames run out, and uniform noise
        foreach (hot_pages[i])
            hot_pages[i] = PAGE_W'($urandom);
        sweep_page = '0;
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mode    = $urandom_range(0, 19);
            run_len = $urandom_range(8, 40);
            if (mode < 12 && $urandom_range(0, 2) == 0)
                for (k = 0; k < 3; k++)
                    hot_pages[$urandom_range(0, HOT_SET-1)] = PAGE_W'($urandom);
            for (k = 0; k < run_len && n < RANDOM_ITEMS; k++)
            begin
                if (n == RANDOM_ITEMS - QUIET_ITEMS)
                begin
                    tx_gaps_on   = 1'b0;
                    rx_stalls_on = 1'b0;
                end
                if (mode < 12)
                    pg = hot_pages[$urandom_range(0, HOT_SET-1)];
                else if (mode < 17)
                begin
                    pg = sweep_page;
                    sweep_page++;
                end
                else
                    pg = PAGE_W'($urandom);
                send_address({pg, OFF_W'($urandom)});
                n++;
            end
            // now and then let everything drain mid-run
            if (tx_gaps_on && $urandom_range(0, 19) == 0)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
